// ===== hdl/osd_text_glyph_rasterizer_assert.svh =====
// Assertion macros for the OSD text glyph rasterizer.
`ifndef OSD_TEXT_GLYPH_RASTERIZER_ASSERT_SVH
`define OSD_TEXT_GLYPH_RASTERIZER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define OSDGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osdgr assertion failed");
// Next-cycle implication, disabled during reset.
`define OSDGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osdgr assertion failed");
`else
`define OSDGR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OSDGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/osdgr_pkg.sv =====
// Shared types, constants and the 5x7 font table of the OSD text glyph rasterizer.
package osdgr_pkg;

    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int MAX_RESULTS   = 14;
    localparam int COORD_BITS    = 10;
    localparam int ADV_BITS      = 8;
    localparam int CODE_BITS     = 8;
    localparam int PIXEL_SCALE_DEF = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ROW_BITS      = $clog2(MAX_RESULTS);
    localparam int GROW_BITS     = $clog2(GLYPH_ROWS);

    localparam logic [CODE_BITS-1:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAR_ADVANCE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_ADVANCE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SURFACE_HEIGHT = 3'd5;

    // Register reset values
    localparam logic [COORD_BITS-1:0] ORIGIN_X_RST       = 10'd8;
    localparam logic [COORD_BITS-1:0] ORIGIN_Y_RST       = 10'd7;
    localparam logic [ADV_BITS-1:0]   CHAR_ADVANCE_RST   = 8'd12;
    localparam logic [ADV_BITS-1:0]   LINE_ADVANCE_RST   = 8'd18;
    localparam logic [COORD_BITS-1:0] SURFACE_WIDTH_RST  = 10'd590;
    localparam logic [COORD_BITS-1:0] SURFACE_HEIGHT_RST = 10'd390;

    typedef struct packed {
        logic [CODE_BITS-1:0] char_code;
        logic                 new_text;
    } t_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] row_x;
        logic [COORD_BITS-1:0] row_y;
        logic [COORD_BITS-1:0] row_mask;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] origin_x;
        logic [COORD_BITS-1:0] origin_y;
        logic [ADV_BITS-1:0]   char_advance;
        logic [ADV_BITS-1:0]   line_advance;
        logic [COORD_BITS-1:0] surface_width;
        logic [COORD_BITS-1:0] surface_height;
    } t_cfg;

    // Top glyph row sits at the highest index
    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] t_glyph;

    typedef struct packed {
        t_glyph                glyph;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_job;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // Look up the glyph rows of a character; unknown codes are blank
    function automatic t_glyph font_glyph(input logic [CODE_BITS-1:0] code);
        t_glyph g;
        case (code)
            8'h30: g = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}; // 0
            8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E}; // 1
            8'h32: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}; // 2
            8'h33: g = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E}; // 3
            8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}; // 4
            8'h35: g = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E}; // 5
            8'h36: g = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E}; // 6
            8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08}; // 7
            8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}; // 8
            8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E}; // 9
            8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}; // A
            8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E}; // B
            8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E}; // C
            8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E}; // D
            8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F}; // E
            8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10}; // F
            8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E}; // G
            8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}; // H
            8'h49: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E}; // I
            8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C}; // J
            8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}; // K
            8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F}; // L
            8'h4D: g = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11}; // M
            8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11}; // N
            8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}; // O
            8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10}; // P
            8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D}; // Q
            8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11}; // R
            8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E}; // S
            8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}; // T
            8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E}; // U
            8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04}; // V
            8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A}; // W
            8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11}; // X
            8'h59: g = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04}; // Y
            8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}; // Z
            8'h78: g = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11}; // x
            8'h3A: g = {5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00}; // colon
            8'h2F: g = {5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10}; // slash
            8'h2B: g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00}; // plus
            8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00}; // minus
            8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06}; // period
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== hdl/osdgr_front.sv =====
// Front end: accepts characters, tracks the cursor and queues drawn glyphs.
module osdgr_front #(
    parameter int PIXEL_SCALE = osdgr_pkg::PIXEL_SCALE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  osdgr_pkg::t_cfg i_cfg,
    input  logic            i_accept,
    input  osdgr_pkg::t_in  i_in,
    output logic            o_push,
    output osdgr_pkg::t_job o_job
);
    import osdgr_pkg::*;

    localparam int FULL_ROWS = GLYPH_ROWS * PIXEL_SCALE;
    localparam int SUM_BITS  = COORD_BITS + 1;

    logic [COORD_BITS-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_BITS-1:0] r_cursor_y, n_cursor_y;
    logic                  r_stopped,  n_stopped;

    logic [COORD_BITS-1:0] cur_x, cur_y;
    logic                  stop_eff, is_nl, wrap, stop_new;
    logic [SUM_BITS-1:0]   nx, nx2, ny, ny_bottom;

    // Apply a new-text restart before anything else
    always_comb begin
        cur_x    = i_in.new_text ? i_cfg.origin_x : r_cursor_x;
        cur_y    = i_in.new_text ? i_cfg.origin_y : r_cursor_y;
        stop_eff = r_stopped && !i_in.new_text;
        is_nl    = (i_in.char_code == NEWLINE_CODE);
    end

    // Compute advance, wrap and bottom-edge tests
    always_comb begin
        nx        = {1'b0, cur_x} + SUM_BITS'(i_cfg.char_advance);
        nx2       = nx + SUM_BITS'(i_cfg.char_advance);
        ny        = {1'b0, cur_y} + SUM_BITS'(i_cfg.line_advance);
        ny_bottom = ny + SUM_BITS'(FULL_ROWS);
        wrap      = is_nl || (nx2 >= {1'b0, i_cfg.surface_width});
        stop_new  = ny_bottom >= {1'b0, i_cfg.surface_height};
    end

    // Update cursor on each accepted transaction
    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_stopped  = r_stopped;
        if (i_accept && !stop_eff) begin
            if (wrap) begin
                n_cursor_x = i_cfg.origin_x;
                n_cursor_y = ny[COORD_BITS-1:0];
                n_stopped  = stop_new;
            end else begin
                n_cursor_x = nx[COORD_BITS-1:0];
                n_cursor_y = cur_y;
                n_stopped  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= ORIGIN_X_RST;
            r_cursor_y <= ORIGIN_Y_RST;
            r_stopped  <= 1'b0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_stopped  <= n_stopped;
        end
    end

    // Queue a glyph job for every drawn character
    assign o_push      = i_accept && !stop_eff && !is_nl;
    assign o_job.glyph = font_glyph(i_in.char_code);
    assign o_job.x     = cur_x;
    assign o_job.y     = cur_y;

endmodule

// ===== hdl/osdgr_queue.sv =====
// Short job queue between the front end and the row sequencer.
module osdgr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  osdgr_pkg::t_job    i_job,
    input  logic               i_pop,
    output osdgr_pkg::t_job    o_head,
    output osdgr_pkg::t_q_stat o_stat
);
    import osdgr_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_job                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Store incoming jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);

endmodule

// ===== hdl/osdgr_back.sv =====
// Back end: steps through the scaled rows of a glyph and clips each mask.
module osdgr_back #(
    parameter int PIXEL_SCALE = osdgr_pkg::PIXEL_SCALE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  osdgr_pkg::t_cfg    i_cfg,
    input  osdgr_pkg::t_job    i_head,
    input  osdgr_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output osdgr_pkg::t_out    o_out_data
);
    import osdgr_pkg::*;

    localparam int MASK_W   = GLYPH_COLS * PIXEL_SCALE;
    localparam int ALL_ROWS = GLYPH_ROWS * PIXEL_SCALE;
    localparam int NUM_ROWS = (ALL_ROWS > MAX_RESULTS) ? MAX_RESULTS : ALL_ROWS;
    localparam int SUB_BITS = (PIXEL_SCALE > 1) ? $clog2(PIXEL_SCALE) : 1;
    localparam int SUM_BITS = COORD_BITS + 1;

    logic [ROW_BITS-1:0]   r_row;
    logic [SUB_BITS-1:0]   r_sub;
    logic [GROW_BITS-1:0]  r_grow;
    logic                  r_out_valid;
    t_out                  r_out;

    logic                  out_adv, load, row_last;
    logic [GLYPH_COLS-1:0] grow_bits;
    logic [SUM_BITS-1:0]   y_full;
    logic                  y_in;
    logic [COORD_BITS-1:0] col_mask;

    assign out_adv  = !r_out_valid || i_out_ready;
    assign load     = i_q_stat.valid && out_adv;
    assign row_last = (r_row == ROW_BITS'(NUM_ROWS - 1));
    assign o_pop    = load && row_last;

    // Select the glyph row and test the vertical clip
    assign grow_bits = i_head.glyph[GROW_BITS'(GLYPH_ROWS - 1) - r_grow];
    assign y_full    = {1'b0, i_head.y} + SUM_BITS'(r_row);
    assign y_in      = y_full < {1'b0, i_cfg.surface_height};

    // Expand each glyph bit over the scaled columns and clip at the right edge
    for (genvar b = 0; b < COORD_BITS; b++) begin : g_px
        if (b < MASK_W) begin : g_on
            localparam int P  = MASK_W - 1 - b;
            localparam int GX = P / PIXEL_SCALE;
            assign col_mask[b] = grow_bits[GLYPH_COLS - 1 - GX]
                && (({1'b0, i_head.x} + SUM_BITS'(P)) < {1'b0, i_cfg.surface_width});
        end else begin : g_off
            assign col_mask[b] = 1'b0;
        end
    end

    // Step row counters as rows leave for the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_sub  <= '0;
            r_grow <= '0;
        end else if (load) begin
            if (row_last) begin
                r_row  <= '0;
                r_sub  <= '0;
                r_grow <= '0;
            end else begin
                r_row <= r_row + 1'b1;
                if (r_sub == SUB_BITS'(PIXEL_SCALE - 1)) begin
                    r_sub  <= '0;
                    r_grow <= r_grow + 1'b1;
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
            end
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= i_q_stat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.row_x    <= i_head.x;
            r_out.row_y    <= y_full[COORD_BITS-1:0];
            r_out.row_mask <= y_in ? col_mask : '0;
            r_out.last     <= row_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/osd_text_glyph_rasterizer.sv =====
// Top level of the OSD text glyph rasterizer: configuration, front end, queue, row sequencer.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (char_code, new_text)
//  out      output     o_out_valid / i_out_ready  o_out_data (row_x, row_y, row_mask, last)
//  cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A drawn character yields min(7*PIXEL_SCALE, 14) rows, one per cycle from the row
// sequencer while the output is not stalled.
// Newlines and dropped characters push no job and take no back-end time.
// The front end takes a character every cycle while the two-entry job queue has room.
// Reset is synchronous: registers return to defaults, cursor to origin, queue empties.
// A stalled output holds its row; the queue fills and then lowers o_in_ready.
module osd_text_glyph_rasterizer #(
    parameter int PIXEL_SCALE = osdgr_pkg::PIXEL_SCALE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  osdgr_pkg::t_in                       i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output osdgr_pkg::t_out                      o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [osdgr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [osdgr_pkg::COORD_BITS-1:0]     i_cfg_data
);
    import osdgr_pkg::*;

`include "osd_text_glyph_rasterizer_assert.svh"

    t_cfg    r_cfg;
    t_job    front_job, head_job;
    t_q_stat q_stat;
    logic    in_accept, q_push, q_pop;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= ORIGIN_X_RST;
            r_cfg.origin_y       <= ORIGIN_Y_RST;
            r_cfg.char_advance   <= CHAR_ADVANCE_RST;
            r_cfg.line_advance   <= LINE_ADVANCE_RST;
            r_cfg.surface_width  <= SURFACE_WIDTH_RST;
            r_cfg.surface_height <= SURFACE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:       r_cfg.origin_x       <= i_cfg_data;
                CFG_ORIGIN_Y:       r_cfg.origin_y       <= i_cfg_data;
                CFG_CHAR_ADVANCE:   r_cfg.char_advance   <= i_cfg_data[ADV_BITS-1:0];
                CFG_LINE_ADVANCE:   r_cfg.line_advance   <= i_cfg_data[ADV_BITS-1:0];
                CFG_SURFACE_WIDTH:  r_cfg.surface_width  <= i_cfg_data;
                CFG_SURFACE_HEIGHT: r_cfg.surface_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a transaction whenever the job queue has room
    assign o_in_ready = !q_stat.full;
    assign in_accept  = i_in_valid && o_in_ready;

    osdgr_front #(
        .PIXEL_SCALE (PIXEL_SCALE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (in_accept),
        .i_in     (i_in_data),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    osdgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    osdgr_back #(
        .PIXEL_SCALE (PIXEL_SCALE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A job never enters a full queue, and a job leaves only with its final row
    `OSDGR_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_push, !q_stat.full)
    `OSDGR_ASSERT_NOW(a_pop_has_job, i_clk, i_rst_n, q_pop, q_stat.valid)
    `OSDGR_ASSERT_NEXT(a_pop_marks_last, i_clk, i_rst_n, q_pop, o_out_valid && o_out_data.last)

endmodule

// ===== tb/sv/osd_text_glyph_rasterizer_tb.sv =====
// Self-checking testbench for the OSD text glyph rasterizer: text stimulus, row scoreboard.
`timescale 1ns / 100ps

module osd_text_glyph_rasterizer_tb;
    import osdgr_pkg::*;

    localparam int SCALE          = PIXEL_SCALE_DEF;
    localparam int MASK_W         = GLYPH_COLS * SCALE;
    localparam int ROWS_PER_CHAR  = (GLYPH_ROWS * SCALE > MAX_RESULTS) ?
                                    MAX_RESULTS : GLYPH_ROWS * SCALE;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] t_font_rows;

    // Predicts the row masks of each character and checks them in order
    class glyph_row_scoreboard;
        t_cfg            regs;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        bit              halted;
        t_out            rows_due[$];
        int              errors;
        int              n_drawn;
        int              n_newlines;
        int              n_dropped;
        int              n_checked;
        int              n_settings;

        function new();
            regs.origin_x       = ORIGIN_X_RST;
            regs.origin_y       = ORIGIN_Y_RST;
            regs.char_advance   = CHAR_ADVANCE_RST;
            regs.line_advance   = LINE_ADVANCE_RST;
            regs.surface_width  = SURFACE_WIDTH_RST;
            regs.surface_height = SURFACE_HEIGHT_RST;
            cur_x      = ORIGIN_X_RST;
            cur_y      = ORIGIN_Y_RST;
            halted     = 1'b0;
            errors     = 0;
            n_drawn    = 0;
            n_newlines = 0;
            n_dropped  = 0;
            n_checked  = 0;
            n_settings = 1;
        endfunction

        function void set_regs(t_cfg c);
            regs = c;
            n_settings++;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // 5x7 font, top row first, bit 4 is the leftmost column
        function t_font_rows font_bitmap(logic [CODE_BITS-1:0] code);
            t_font_rows g;
            case (code)
                "0": g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
                "1": g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
                "2": g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
                "3": g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
                "4": g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
                "5": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
                "6": g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
                "7": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
                "8": g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
                "9": g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
                "A": g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                "B": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
                "C": g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
                "D": g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
                "E": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
                "F": g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
                "G": g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
                "H": g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
                "I": g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
                "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
                "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
                "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
                "M": g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
                "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
                "O": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                "P": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
                "Q": g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
                "R": g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
                "S": g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
                "T": g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
                "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
                "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
                "X": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
                "Y": g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
                "Z": g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
                "x": g = {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
                ":": g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
                "/": g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
                "+": g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
                "-": g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
                ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
                default: g = '0;
            endcase
            return g;
        endfunction

        // Move to the next text line; stop once the line would cross the bottom
        function void next_line();
            int unsigned ny;
            ny    = 32'(cur_y) + 32'(regs.line_advance);
            cur_x = regs.origin_x;
            if (ny + 32'(GLYPH_ROWS * SCALE) >= 32'(regs.surface_height))
                halted = 1'b1;
            cur_y = ny[COORD_BITS-1:0];
        endfunction

        // Note an accepted character; returns 1 when it was not dropped
        function bit note_char(t_in item);
            t_font_rows  g;
            t_out        row;
            int unsigned y;
            int unsigned nx;
            if (item.new_text) begin
                cur_x  = regs.origin_x;
                cur_y  = regs.origin_y;
                halted = 1'b0;
            end
            if (halted) begin
                n_dropped++;
                return 1'b0;
            end
            if (item.char_code == NEWLINE_CODE) begin
                n_newlines++;
                next_line();
                return 1'b1;
            end
            n_drawn++;
            g = font_bitmap(item.char_code);
            for (int r = 0; r < ROWS_PER_CHAR; r++) begin
                y            = 32'(cur_y) + 32'(r);
                row.row_x    = cur_x;
                row.row_y    = y[COORD_BITS-1:0];
                row.row_mask = '0;
                row.last     = (r == ROWS_PER_CHAR - 1);
                // clip rows below the surface and columns right of it
                if (y < 32'(regs.surface_height)) begin
                    for (int p = 0; p < MASK_W; p++) begin
                        if (g[r / SCALE][GLYPH_COLS - 1 - p / SCALE] &&
                            (32'(cur_x) + 32'(p) < 32'(regs.surface_width)))
                            row.row_mask[MASK_W - 1 - p] = 1'b1;
                    end
                end
                rows_due.push_back(row);
            end
            // advance, wrapping when the next cell would reach the right margin
            nx = 32'(cur_x) + 32'(regs.char_advance);
            if (nx + 32'(regs.char_advance) >= 32'(regs.surface_width))
                next_line();
            else
                cur_x = nx[COORD_BITS-1:0];
            return 1'b1;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        // Compare an accepted row with the oldest expected one
        task check_row(t_out got);
            t_out want;
            if (rows_due.size() == 0) begin
                report($sformatf("unexpected row x=%0d y=%0d mask=%03h last=%0b",
                                 got.row_x, got.row_y, got.row_mask, got.last));
                return;
            end
            want = rows_due.pop_front();
            n_checked++;
            if (got.row_x !== want.row_x || got.row_y !== want.row_y ||
                got.row_mask !== want.row_mask || got.last !== want.last)
                report($sformatf({"row got x=%0d y=%0d mask=%03h last=%0b, ",
                                  "want x=%0d y=%0d mask=%03h last=%0b"},
                                 got.row_x, got.row_y, got.row_mask, got.last,
                                 want.row_x, want.row_y, want.row_mask, want.last));
        endtask
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    t_in                     in_data   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    t_out                    out_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx   = CFG_ORIGIN_X;
    logic [COORD_BITS-1:0]   cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    string font_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZx:/+-.";

    glyph_row_scoreboard sb = new();

    osd_text_glyph_rasterizer uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the row channel at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Check every accepted row transaction
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_row(out_data);

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] ERROR: no transaction for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic t_in text_item(logic [CODE_BITS-1:0] code, logic nt);
        t_in item;
        item.char_code = code;
        item.new_text  = nt;
        return item;
    endfunction

    // Offer one character, idling first at random; returns 1 unless it was dropped
    task automatic send_char(input t_in item, output bit useful);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        useful = sb.note_char(item);
    endtask

    // Hold off the input until every expected row has come, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Program all six registers while the block is idle
    task automatic load_regs(input t_cfg c);
        write_reg(CFG_ORIGIN_X, c.origin_x);
        write_reg(CFG_ORIGIN_Y, c.origin_y);
        write_reg(CFG_CHAR_ADVANCE, {2'b00, c.char_advance});
        write_reg(CFG_LINE_ADVANCE, {2'b00, c.line_advance});
        write_reg(CFG_SURFACE_WIDTH, c.surface_width);
        write_reg(CFG_SURFACE_HEIGHT, c.surface_height);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_regs(c);
    endtask

    task automatic send_list(input t_in items[$]);
        bit useful;
        foreach (items[i])
            send_char(items[i], useful);
    endtask

    // Random text: mostly lines of font characters that start a new text, some noise
    task automatic run_text(input int target);
        int   sent_cnt;
        int   text_left;
        int   pick;
        bit   useful;
        t_in  item;
        sent_cnt  = 0;
        text_left = 0;
        while (sent_cnt < target) begin
            if (text_left == 0) begin
                text_left     = $urandom_range(4, 16);
                item.new_text = ($urandom_range(9) != 0);
            end else begin
                item.new_text = ($urandom_range(99) < 3);
            end
            text_left--;
            pick = $urandom_range(99);
            if (pick < 70)
                item.char_code = font_chars[$urandom_range(font_chars.len() - 1)];
            else if (pick < 80)
                item.char_code = NEWLINE_CODE;
            else
                item.char_code = 8'($urandom_range(255));
            send_char(item, useful);
            sent_cnt++;
            // wait for the rows to drain once mid-stream
            if (sent_cnt == target / 2)
                drain();
        end
    endtask

    initial begin
        t_cfg  c;
        t_in   items[$];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: every font extreme, blank codes, high bytes, newline
        items = {text_item("0", 1'b1), text_item("Z", 1'b0), text_item("x", 1'b0),
                 text_item(":", 1'b0), text_item("/", 1'b0), text_item("+", 1'b0),
                 text_item("-", 1'b0), text_item(".", 1'b0), text_item(8'h00, 1'b0),
                 text_item(8'hFF, 1'b0), text_item(8'h80, 1'b0), text_item("9", 1'b0),
                 text_item("A", 1'b0), text_item(NEWLINE_CODE, 1'b0),
                 text_item("M", 1'b0)};
        send_list(items);
        drain();

        // Far corner: right and bottom clipping, coordinates wrapping, stop and restart
        c = '{origin_x: 10'd1016, origin_y: 10'd1012, char_advance: 8'd255,
              line_advance: 8'd255, surface_width: 10'd1023, surface_height: 10'd1023};
        load_regs(c);
        items = {text_item("W", 1'b1), text_item("H", 1'b0), text_item("8", 1'b1),
                 text_item(NEWLINE_CODE, 1'b0), text_item(NEWLINE_CODE, 1'b1)};
        send_list(items);
        drain();

        // Smallest surface with the origin outside it: all pixels clipped, stop at once
        c = '{origin_x: 10'd1023, origin_y: 10'd1023, char_advance: 8'd1,
              line_advance: 8'd1, surface_width: 10'd1, surface_height: 10'd1};
        load_regs(c);
        items = {text_item("8", 1'b1), text_item("A", 1'b0)};
        send_list(items);
        drain();

        // Unit steps on the largest surface, no idling
        c = '{origin_x: 10'd0, origin_y: 10'd0, char_advance: 8'd1,
              line_advance: 8'd1, surface_width: 10'd1023, surface_height: 10'd1023};
        load_regs(c);
        run_text(37);
        drain();

        // Moderate layout, sender mostly idle
        c.origin_x       = 10'($urandom_range(0, 63));
        c.origin_y       = 10'($urandom_range(0, 63));
        c.char_advance   = 8'($urandom_range(6, 16));
        c.line_advance   = 8'($urandom_range(10, 30));
        c.surface_width  = 10'($urandom_range(60, 400));
        c.surface_height = 10'($urandom_range(40, 300));
        load_regs(c);
        send_idle_pct = 82;
        run_text(37);
        drain();

        // Any layout, receiver mostly stalled
        c.origin_x       = 10'($urandom_range(0, 1023));
        c.origin_y       = 10'($urandom_range(0, 1023));
        c.char_advance   = 8'($urandom_range(1, 255));
        c.line_advance   = 8'($urandom_range(1, 255));
        c.surface_width  = 10'($urandom_range(1, 1023));
        c.surface_height = 10'($urandom_range(1, 1023));
        load_regs(c);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_text(37);
        drain();

        // Tiny surfaces, light idling on both sides
        c.origin_x       = 10'($urandom_range(0, 3));
        c.origin_y       = 10'($urandom_range(0, 3));
        c.char_advance   = 8'($urandom_range(1, 6));
        c.line_advance   = 8'($urandom_range(1, 6));
        c.surface_width  = 10'($urandom_range(1, 24));
        c.surface_height = 10'($urandom_range(1, 40));
        load_regs(c);
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        run_text(37);
        drain();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected rows never arrived", sb.pending()));
        $display("Run covered %0d characters: %0d drawn, %0d newlines, %0d dropped after a stop.",
                 sb.n_drawn + sb.n_newlines + sb.n_dropped, sb.n_drawn, sb.n_newlines,
                 sb.n_dropped);
        $display("%0d row transactions checked over %0d register settings, %0d mismatches.",
                 sb.n_checked, sb.n_settings, sb.errors);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/osdgr_pkg.sv
hdl/osdgr_front.sv
hdl/osdgr_queue.sv
hdl/osdgr_back.sv
hdl/osd_text_glyph_rasterizer.sv
tb/sv/osd_text_glyph_rasterizer_tb.sv
